// ===== rtl/slot_table_free_list_core_macros.svh =====
// Assertion helpers used by the slot table datapath.
// Each macro expects signals named clk and arst_n in the enclosing module.
`ifndef SLOT_TABLE_FREE_LIST_CORE_MACROS_SVH
`define SLOT_TABLE_FREE_LIST_CORE_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define STFL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Property whose consequent must hold in the cycle after its antecedent.
`define STFL_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== rtl/stfl_pkg.sv =====
package stfl_pkg;

	localparam int SLOTS_DEF      = 64;
	localparam int DATA_WIDTH_DEF = 32;

	// opcodes
	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_DEL = 2'd1;
	localparam logic [1:0] OP_GET = 2'd2;
	localparam logic [1:0] OP_NOP = 2'd3;

	// result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;
	localparam logic [1:0] ST_EMPTY = 2'd3;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [6:0]  slot_index;
		logic [31:0] entry_data;
	} req_beat_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [5:0]  assigned_index;
		logic [31:0] data_out;
		logic [6:0]  occupancy;
		logic        has_space;
	} rsp_beat_t;

	typedef enum logic [1:0] {
		S_INIT,
		S_IDLE,
		S_EXEC
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic clr;     // one step of the post-reset link/valid sweep
		logic accept;  // latch the request beat and launch RAM reads
		logic commit;  // write back state and load the response register
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;  // sweep is at the last slot
		logic out_busy;  // response register holds an untaken beat
	} dp_sts_t;

endpackage

// ===== rtl/stfl_ram.sv =====
module stfl_ram
	#(
		parameter int WIDTH = 32,
		parameter int DEPTH = 64
	)
	(
		input  logic                     clk,
		input  logic                     we,
		input  logic [$clog2(DEPTH)-1:0] waddr,
		input  logic [WIDTH-1:0]         wdata,
		input  logic                     re,
		input  logic [$clog2(DEPTH)-1:0] raddr,
		output logic [WIDTH-1:0]         rdata
	);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/stfl_ctrl.sv =====
module stfl_ctrl
	import stfl_pkg::*;
	(
		input  logic       clk,
		input  logic       arst_n,
		input  logic       req_valid,
		output logic       req_stall,
		input  dp_sts_t    sts,
		output ctrl_cmd_t  cmd
	);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_stall = 1'b1;
		case (state_q)
			S_INIT: begin
				cmd.clr = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.accept = 1'b1;
					state_d    = S_EXEC;
				end
			end
			S_EXEC: begin
				// hold until the response register can take the result
				if (!sts.out_busy) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_INIT;
			end
		endcase
	end

endmodule

// ===== rtl/stfl_dp.sv =====
`include "slot_table_free_list_core_macros.svh"

module stfl_dp
	import stfl_pkg::*;
	#(
		parameter int SLOTS      = SLOTS_DEF,
		parameter int DATA_WIDTH = DATA_WIDTH_DEF
	)
	(
		input  logic       clk,
		input  logic       arst_n,
		input  req_beat_t  req,
		output rsp_beat_t  rsp,
		output logic       rsp_valid,
		input  logic       rsp_stall,
		input  ctrl_cmd_t  cmd,
		output dp_sts_t    sts
	);

	localparam int IW = $clog2(SLOTS);
	localparam int HW = IW + 1;
	localparam int XW = ((IW > 7) ? IW : 7) + 1;
	localparam int CW = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
	localparam logic [HW-1:0] CNT_FULL = HW'(SLOTS);
	localparam logic [HW-1:0] CLR_LAST = HW'(SLOTS - 1);

	// control state
	logic [HW-1:0] head_q;
	logic [HW-1:0] count_q;
	logic [HW-1:0] clr_q;
	logic          rsp_valid_q;

	// latched request
	logic [1:0]            op_q;
	logic [IW-1:0]         addr_q;
	logic                  inr_q;
	logic [DATA_WIDTH-1:0] wdata_q;

	rsp_beat_t rsp_q;

	logic [XW-1:0]         idx_x;
	logic                  in_range;
	logic [DATA_WIDTH-1:0] entry_rd;
	logic [HW-1:0]         link_rd;
	logic                  valid_rd;

	logic [1:0]            st_d;
	logic [IW-1:0]         asg_d;
	logic [DATA_WIDTH-1:0] dout_d;
	logic [HW-1:0]         head_d;
	logic [HW-1:0]         cnt_d;
	logic                  full;
	logic                  ent_we;
	logic                  lnk_we;
	logic                  vld_we;
	logic                  vld_wd;

	logic [IW-1:0] lnk_waddr;
	logic [HW-1:0] lnk_wdata;
	logic [IW-1:0] vld_waddr;

	assign idx_x    = XW'(req.slot_index);
	assign in_range = idx_x < XW'(SLOTS);
	assign full     = (count_q >= CNT_FULL) || (head_q >= CNT_FULL);

	// execute: decide result and state update from the latched beat and RAM reads
	always_comb begin
		st_d   = ST_OK;
		asg_d  = '0;
		dout_d = '0;
		head_d = head_q;
		cnt_d  = count_q;
		ent_we = 1'b0;
		lnk_we = 1'b0;
		vld_we = 1'b0;
		vld_wd = 1'b0;
		case (op_q)
			OP_ADD: begin
				if (full) begin
					st_d = ST_FULL;
				end else begin
					ent_we = 1'b1;
					vld_we = 1'b1;
					vld_wd = 1'b1;
					head_d = link_rd;
					cnt_d  = count_q + 1'b1;
					asg_d  = head_q[IW-1:0];
				end
			end
			OP_DEL, OP_GET: begin
				if (!inr_q) begin
					st_d = ST_RANGE;
				end else if (!valid_rd) begin
					st_d = ST_EMPTY;
				end else begin
					dout_d = entry_rd;
					if (op_q == OP_DEL) begin
						lnk_we = 1'b1;
						vld_we = 1'b1;
						head_d = HW'(addr_q);
						if (count_q != '0) begin
							cnt_d = count_q - 1'b1;
						end
					end
				end
			end
			default: begin
				st_d = ST_OK;
			end
		endcase
	end

	assign lnk_waddr = cmd.clr ? clr_q[IW-1:0] : addr_q;
	assign lnk_wdata = cmd.clr ? (clr_q + 1'b1) : head_q;
	assign vld_waddr = cmd.clr ? clr_q[IW-1:0] :
		((op_q == OP_ADD) ? head_q[IW-1:0] : addr_q);

	stfl_ram #(.WIDTH(DATA_WIDTH), .DEPTH(SLOTS)) u_entry_ram (
		.clk   (clk),
		.we    (ent_we && cmd.commit),
		.waddr (head_q[IW-1:0]),
		.wdata (wdata_q),
		.re    (cmd.accept),
		.raddr (idx_x[IW-1:0]),
		.rdata (entry_rd)
	);

	stfl_ram #(.WIDTH(HW), .DEPTH(SLOTS)) u_link_ram (
		.clk   (clk),
		.we    (cmd.clr || (lnk_we && cmd.commit)),
		.waddr (lnk_waddr),
		.wdata (lnk_wdata),
		.re    (cmd.accept),
		.raddr (head_q[IW-1:0]),
		.rdata (link_rd)
	);

	stfl_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_valid_ram (
		.clk   (clk),
		.we    (cmd.clr || (vld_we && cmd.commit)),
		.waddr (vld_waddr),
		.wdata (vld_wd && !cmd.clr),
		.re    (cmd.accept),
		.raddr (idx_x[IW-1:0]),
		.rdata (valid_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			count_q     <= '0;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.clr) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.commit) begin
				head_q      <= head_d;
				count_q     <= cnt_d;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q    <= req.opcode;
			addr_q  <= idx_x[IW-1:0];
			inr_q   <= in_range;
			wdata_q <= DATA_WIDTH'(req.entry_data[CW-1:0]);
		end
		if (cmd.commit) begin
			rsp_q.status         <= st_d;
			rsp_q.assigned_index <= 6'(asg_d);
			rsp_q.data_out       <= 32'(dout_d[CW-1:0]);
			rsp_q.occupancy      <= 7'(cnt_d);
			rsp_q.has_space      <= cnt_d < CNT_FULL;
		end
	end

	assign rsp          = rsp_q;
	assign rsp_valid    = rsp_valid_q;
	assign sts.clr_last = clr_q == CLR_LAST;
	assign sts.out_busy = rsp_valid_q && rsp_stall;

	`STFL_ASSERT(a_count_max, count_q <= CNT_FULL, "occupancy above capacity")
	`STFL_ASSERT(a_full_head, (count_q == CNT_FULL) == (head_q == CNT_FULL), "free head out of step with occupancy")
	`STFL_ASSERT(a_commit_free, !(cmd.commit && rsp_valid_q && rsp_stall), "commit over an untaken response")
	`STFL_ASSERT_NEXT(a_commit_valid, cmd.commit, rsp_valid_q, "commit did not raise response valid")

endmodule

// ===== rtl/slot_table_free_list_core.sv =====
// Slot table with a LIFO free list. An add takes the slot at the head of the
// free list, stores the entry there and returns its index; a delete hands
// back the stored entry and pushes the slot onto the head of the list; a get
// reads an entry without changing anything. Every response beat also carries
// the occupancy and a has-space flag. Requests are processed one at a time:
// a beat is accepted, its response is registered once the response register
// is free, and no new beat is taken before that. The order comes from the
// registered-read slot RAMs: the entry, valid flag and free link are read
// first, and the update is written back afterwards. After reset the block
// keeps req_stall high while it sweeps the link and valid RAMs so that the
// free list runs through the slots in ascending order and every slot reads
// as empty.
module slot_table_free_list_core
	import stfl_pkg::*;
	#(
		parameter int SLOTS      = SLOTS_DEF,
		parameter int DATA_WIDTH = DATA_WIDTH_DEF
	)
	(
		input  logic      clk,
		input  logic      arst_n,
		// request channel
		input  logic      req_valid,
		output logic      req_stall,
		input  req_beat_t req,
		// response channel
		output logic      rsp_valid,
		input  logic      rsp_stall,
		output rsp_beat_t rsp
	);

	// command and status between the sequencer and the datapath
	ctrl_cmd_t cmd;
	dp_sts_t   sts;

	// Sequencer: run the init sweep, accept a beat, then commit it once the
	// response register is free.
	stfl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Datapath: slot RAMs, free head, occupancy counter and response register.
	stfl_dp #(
		.SLOTS      (SLOTS),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

// ===== bench/slot_table_free_list_core_tb.sv =====
module slot_table_free_list_core_tb;
	import stfl_pkg::*;

	localparam int SLOTS = SLOTS_DEF;

	// Mirror of the slot table: tracks the stored entries, the free list and
	// the occupancy, and queues the response beat that each request beat must
	// produce, in order.
	class slot_table_mirror;
		logic [31:0] stored [SLOTS];
		logic [6:0]  link [SLOTS];
		bit          in_use [SLOTS];
		logic [6:0]  head;
		logic [6:0]  count;
		rsp_beat_t   replies_due [$];
		int          fails;

		function new();
			for (int i = 0; i < SLOTS; i++) begin
				stored[i] = '0;
				link[i] = 7'(i + 1);
				in_use[i] = 1'b0;
			end
			head = '0;
			count = '0;
			fails = 0;
		endfunction

		function int pending();
			return replies_due.size();
		endfunction

		// Random slot whose occupied flag equals want; 0 if there is none.
		function logic [5:0] any_slot(bit want);
			int start;
			int s;
			start = $urandom_range(SLOTS - 1);
			for (int k = 0; k < SLOTS; k++) begin
				s = (start + k) % SLOTS;
				if (in_use[s] == want)
					return 6'(s);
			end
			return '0;
		endfunction

		function void note_request(req_beat_t r);
			rsp_beat_t  e;
			logic [5:0] s;
			e = '0;
			e.status = ST_OK;
			s = r.slot_index[5:0];
			case (r.opcode)
				OP_ADD: begin
					if (count >= SLOTS || head >= SLOTS) begin
						e.status = ST_FULL;
					end else begin
						s = head[5:0];
						head = link[s];
						stored[s] = r.entry_data;
						in_use[s] = 1'b1;
						count = count + 7'd1;
						e.assigned_index = s;
					end
				end
				OP_DEL, OP_GET: begin
					if (r.slot_index >= SLOTS) begin
						e.status = ST_RANGE;
					end else if (!in_use[s]) begin
						e.status = ST_EMPTY;
					end else begin
						e.data_out = stored[s];
						if (r.opcode == OP_DEL) begin
							link[s] = head;
							head = {1'b0, s};
							in_use[s] = 1'b0;
							if (count != 0)
								count = count - 7'd1;
						end
					end
				end
				default: ;
			endcase
			e.occupancy = count;
			e.has_space = (count < SLOTS);
			replies_due.push_back(e);
		endfunction

		function void compare(string field, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
				fails++;
			end
		endfunction

		function void check_reply(rsp_beat_t got);
			rsp_beat_t want;
			if (replies_due.size() == 0) begin
				$error("response beat with nothing expected: 0x%0h", got);
				fails++;
				return;
			end
			want = replies_due.pop_front();
			compare("status", 32'(want.status), 32'(got.status));
			compare("assigned_index", 32'(want.assigned_index), 32'(got.assigned_index));
			compare("data_out", want.data_out, got.data_out);
			compare("occupancy", 32'(want.occupancy), 32'(got.occupancy));
			compare("has_space", 32'(want.has_space), 32'(got.has_space));
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      req_valid;
	logic      req_stall;
	req_beat_t req;
	logic      rsp_valid;
	logic      rsp_stall;
	rsp_beat_t rsp;

	slot_table_mirror mirror = new();

	// Shared between the request and response processes: quiet turns off
	// random idling on both sides, hold_go asks the response side for a long
	// hold-off.
	bit quiet;
	bit hold_go;

	slot_table_free_list_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Generous bound on the length of the slowest legal run.
	initial begin
		#3000000;
		$display("slot_table_free_list_core: mismatch");
		$finish;
	end

	// Check every response beat taken at an edge against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			mirror.check_reply(rsp);
	end

	// Response side: random stalls, a quiet stretch, and one long hold-off
	// counted here so that the block backs up into its request port.
	initial begin
		int hold_cnt;
		hold_cnt = 0;
		rsp_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cnt > 0) begin
				hold_cnt--;
				rsp_stall <= 1'b1;
			end else if (hold_go) begin
				hold_go = 1'b0;
				hold_cnt = 300;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= !quiet && ($urandom_range(99) < 31);
			end
		end
	end

	// Offer one request beat, idling at random first, and hold it until taken.
	// Valid stays high on return so back-to-back beats never drop it.
	task automatic send(input req_beat_t b);
		while (!quiet && $urandom_range(99) < 31) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= b;
		do
			@(posedge clk);
		while (req_stall);
		mirror.note_request(b);
	endtask

	task automatic send_op(input logic [1:0] op, input logic [6:0] idx,
			input logic [31:0] data);
		req_beat_t b;
		b.opcode = op;
		b.slot_index = idx;
		b.entry_data = data;
		send(b);
	endtask

	// Stop offering and wait until every predicted response beat has arrived.
	task automatic drain();
		req_valid <= 1'b0;
		while (mirror.pending() != 0)
			@(posedge clk);
	endtask

	// Build a random request beat from the mirror's view of the table. Most
	// deletes and gets aim at occupied slots so the free list gets shuffled;
	// the rest are no-ops, out-of-range indexes and empty slots. add_pct
	// sets how hard the table is pushed toward full.
	function automatic req_beat_t pick_request(int unsigned add_pct);
		req_beat_t   b;
		int unsigned roll;
		b.opcode = OP_ADD;
		b.slot_index = 7'($urandom_range(127));
		b.entry_data = $urandom();
		roll = $urandom_range(99);
		if (roll < add_pct) begin
			b.opcode = OP_ADD;
		end else if (roll < 90) begin
			b.opcode = ($urandom_range(3) == 0) ? OP_GET : OP_DEL;
			if (mirror.count != 0)
				b.slot_index = {1'b0, mirror.any_slot(1'b1)};
		end else begin
			case ($urandom_range(3))
				0: b.opcode = OP_NOP;
				1: begin
					b.opcode = $urandom_range(1) ? OP_DEL : OP_GET;
					b.slot_index = 7'($urandom_range(127, SLOTS));
				end
				default: begin
					b.opcode = $urandom_range(1) ? OP_DEL : OP_GET;
					if (mirror.count < SLOTS)
						b.slot_index = {1'b0, mirror.any_slot(1'b0)};
				end
			endcase
		end
		return b;
	endfunction

	initial begin
		int wait_cycles;
		int unsigned add_pct;
		quiet = 1'b0;
		hold_go = 1'b0;
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty and out-of-range lookups on a fresh table, both data
		// extremes, LIFO reuse of freed slots, and the unused opcode.
		send_op(OP_GET, 7'd0, 32'h0);
		send_op(OP_DEL, 7'd0, 32'hFFFF_FFFF);
		send_op(OP_GET, 7'd127, 32'h0);
		send_op(OP_DEL, 7'd64, 32'h0);
		send_op(OP_GET, 7'd63, 32'h0);
		send_op(OP_NOP, 7'd127, 32'hFFFF_FFFF);
		send_op(OP_ADD, 7'd127, 32'h0000_0000);
		send_op(OP_ADD, 7'd0, 32'hFFFF_FFFF);
		send_op(OP_ADD, 7'd0, 32'hA5A5_A5A5);
		send_op(OP_GET, 7'd1, 32'h0);
		send_op(OP_GET, 7'd0, 32'h0);
		send_op(OP_DEL, 7'd1, 32'h0);
		send_op(OP_ADD, 7'd0, 32'h5A5A_5A5A);
		send_op(OP_DEL, 7'd2, 32'h0);
		send_op(OP_DEL, 7'd0, 32'h0);
		send_op(OP_DEL, 7'd0, 32'h0);
		send_op(OP_ADD, 7'd0, 32'h1234_5678);
		send_op(OP_ADD, 7'd0, 32'h8765_4321);
		send_op(OP_ADD, 7'd0, 32'h0F0F_0F0F);
		send_op(OP_DEL, 7'd127, 32'h0);
		send_op(OP_GET, 7'd64, 32'h0);
		send_op(OP_NOP, 7'd0, 32'h0);
		drain();

		// Random: alternate fill-heavy and drain-heavy runs so the table
		// swings between empty and full, with a quiet stretch, one long
		// response hold-off and one full pause along the way.
		for (int n = 0; n < 850; n++) begin
			if (n % 140 == 0)
				add_pct = ((n / 140) % 2 == 0) ? 75 : 15;
			quiet = (n >= 300 && n < 420);
			if (n == 500)
				hold_go = 1'b1;
			if (n == 650)
				drain();
			send(pick_request(add_pct));
		end
		quiet = 1'b0;

		// Wind down: drop valid, let the last beats come home, then settle.
		req_valid <= 1'b0;
		wait_cycles = 0;
		while (mirror.pending() != 0 && wait_cycles < 5000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (10) @(posedge clk);
		if (mirror.pending() != 0) begin
			$error("%0d response beats never arrived", mirror.pending());
			mirror.fails++;
		end
		if (mirror.fails == 0)
			$display("slot_table_free_list_core: match");
		else
			$display("slot_table_free_list_core: mismatch");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/stfl_pkg.sv
rtl/stfl_ram.sv
rtl/stfl_ctrl.sv
rtl/stfl_dp.sv
rtl/slot_table_free_list_core.sv
bench/slot_table_free_list_core_tb.sv
